@@ rtl/core/tgapsd_pkg.sv @@
// ----------------------------------------------------------------------------
// tgapsd_pkg
// shared types, codes and helpers of the tga pixel stream decoder
// ----------------------------------------------------------------------------
package tgapsd_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_RLE_ENABLE  = 2'd0;
    localparam logic [1:0] CFG_PIXEL_KIND  = 2'd1;
    localparam logic [1:0] CFG_PIXEL_TOTAL = 2'd2;

    // pixel kinds
    localparam logic [2:0] KIND_GRAY8  = 3'd0;
    localparam logic [2:0] KIND_INDEX8 = 3'd1;
    localparam logic [2:0] KIND_RGB555 = 3'd2;
    localparam logic [2:0] KIND_BGR24  = 3'd3;
    localparam logic [2:0] KIND_BGRA32 = 3'd4;

    // command codes
    localparam logic CMD_DATA  = 1'b0;
    localparam logic CMD_TABLE = 1'b1;

    localparam int unsigned MAX_PACKET = 128;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;

    // one decoded pixel leaving the parser
    typedef struct packed {
        logic       valid;
        logic       use_table;
        logic [7:0] idx;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] count;
        logic       last;
    } t_pix_res;

    function automatic logic [2:0] bytes_per_pixel(input logic [2:0] kind);
        logic [2:0] n;
        unique case (kind)
            KIND_GRAY8, KIND_INDEX8: n = 3'd1;
            KIND_RGB555:             n = 3'd2;
            KIND_BGRA32:             n = 3'd4;
            default:                 n = 3'd3;
        endcase
        return n;
    endfunction

endpackage

@@ rtl/core/tgapsd_ctable.sv @@
// ----------------------------------------------------------------------------
// tgapsd_ctable
// colour table memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module tgapsd_ctable #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [23:0]   i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [23:0]   o_rd_data
);

    logic [23:0] r_mem [DEPTH];
    logic [23:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds when no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/tgapsd_parser.sv @@
// ----------------------------------------------------------------------------
// tgapsd_parser
// packet header parsing, pixel assembly, decode and pixel counting
// ----------------------------------------------------------------------------
module tgapsd_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_restart,
    input  logic [31:0]           i_restart_total,
    input  logic                  i_rle_enable,
    input  logic [2:0]            i_pixel_kind,
    input  logic                  i_step,
    input  logic [7:0]            i_byte,
    output tgapsd_pkg::t_pix_res  o_res
);

    typedef enum logic {
        PH_HEADER,
        PH_PIXEL
    } t_phase;

    t_phase      r_phase,        n_phase;
    logic        r_run,          n_run;
    logic [7:0]  r_packet_left,  n_packet_left;
    logic [1:0]  r_bip,          n_bip;
    logic [23:0] r_bytes,        n_bytes;
    logic [31:0] r_pixels_left,  n_pixels_left;
    logic        r_image_done,   n_image_done;

    logic [31:0]          w_px;
    logic [2:0]           w_bpp;
    logic [7:0]           w_cnt;
    tgapsd_pkg::t_pix_res w_res;

    assign w_bpp = tgapsd_pkg::bytes_per_pixel(i_pixel_kind);

    // current byte merged into the partial pixel
    always_comb begin
        case (r_bip)
            2'd0:    w_px = {8'd0, r_bytes[23:8], i_byte};
            2'd1:    w_px = {8'd0, r_bytes[23:16], i_byte, r_bytes[7:0]};
            2'd2:    w_px = {8'd0, i_byte, r_bytes[15:0]};
            default: w_px = {i_byte, r_bytes};
        endcase
    end

    always_comb begin
        n_phase       = r_phase;
        n_run         = r_run;
        n_packet_left = r_packet_left;
        n_bip         = r_bip;
        n_bytes       = r_bytes;
        n_pixels_left = r_pixels_left;
        n_image_done  = r_image_done;
        w_cnt         = 8'd1;
        w_res         = '0;
        w_res.alpha   = tgapsd_pkg::ALPHA_OPAQUE;

        if (i_restart) begin
            n_phase       = PH_HEADER;
            n_run         = 1'b0;
            n_packet_left = 8'd0;
            n_bip         = 2'd0;
            n_bytes       = 24'd0;
            n_pixels_left = i_restart_total;
            n_image_done  = (i_restart_total == 32'd0);
        end else if (i_step && !r_image_done) begin
            if (i_rle_enable && r_phase == PH_HEADER) begin
                n_run         = i_byte[7];
                n_packet_left = {1'b0, i_byte[6:0]} + 8'd1;
                n_phase       = PH_PIXEL;
                n_bip         = 2'd0;
                n_bytes       = 24'd0;
            end else if ({1'b0, r_bip} + 3'd1 < w_bpp) begin
                n_bip   = r_bip + 2'd1;
                n_bytes = w_px[23:0];
            end else begin
                n_bip   = 2'd0;
                n_bytes = 24'd0;

                // decode
                unique case (i_pixel_kind)
                    tgapsd_pkg::KIND_GRAY8: begin
                        w_res.red = w_px[7:0];
                    end
                    tgapsd_pkg::KIND_INDEX8: begin
                        w_res.use_table = 1'b1;
                        w_res.idx       = w_px[7:0];
                    end
                    tgapsd_pkg::KIND_RGB555: begin
                        w_res.red   = {w_px[14:10], 3'b000};
                        w_res.green = {w_px[9:5], 3'b000};
                        w_res.blue  = {w_px[4:0], 3'b000};
                    end
                    tgapsd_pkg::KIND_BGRA32: begin
                        w_res.blue  = w_px[7:0];
                        w_res.green = w_px[15:8];
                        w_res.red   = w_px[23:16];
                        w_res.alpha = w_px[31:24];
                    end
                    default: begin
                        w_res.blue  = w_px[7:0];
                        w_res.green = w_px[15:8];
                        w_res.red   = w_px[23:16];
                    end
                endcase

                // run count or single pixel
                if (i_rle_enable && r_run) begin
                    w_cnt         = r_packet_left;
                    n_packet_left = 8'd0;
                end else if (i_rle_enable && r_packet_left != 8'd0) begin
                    n_packet_left = r_packet_left - 8'd1;
                end

                // clamp to the pixels left
                if ({24'd0, w_cnt} > r_pixels_left) begin
                    w_cnt = r_pixels_left[7:0];
                end
                if (i_rle_enable && n_packet_left == 8'd0) begin
                    n_phase = PH_HEADER;
                end

                n_pixels_left = r_pixels_left - {24'd0, w_cnt};
                n_image_done  = (n_pixels_left == 32'd0);
                w_res.valid   = 1'b1;
                w_res.count   = w_cnt;
                w_res.last    = n_image_done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HEADER;
            r_run         <= 1'b0;
            r_packet_left <= 8'd0;
            r_bip         <= 2'd0;
            r_bytes       <= 24'd0;
            r_pixels_left <= 32'd1;
            r_image_done  <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_run         <= n_run;
            r_packet_left <= n_packet_left;
            r_bip         <= n_bip;
            r_bytes       <= n_bytes;
            r_pixels_left <= n_pixels_left;
            r_image_done  <= n_image_done;
        end
    end

    assign o_res = w_res;

    // done flag tracks the pixel counter
    a_done_matches_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_image_done == (r_pixels_left == 32'd0))
        else $error("image done flag out of step with pixels left");

    // inside a packet there is always at least one pixel to come
    a_packet_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PIXEL) |-> (r_packet_left != 8'd0))
        else $error("packet body with zero pixels left");

    // partial pixel never holds a full pixel's bytes
    a_bip_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_bip} < w_bpp))
        else $error("byte position beyond pixel size");

endmodule

@@ rtl/core/tga_pixel_stream_decoder_top.sv @@
// ----------------------------------------------------------------------------
// tga_pixel_stream_decoder_top
// tga pixel data decoder with rle packets and a colour table lookup
// ----------------------------------------------------------------------------
// a result is registered on the edge that accepts the byte that completes its pixel
// throughput: one transaction per cycle while the input is not stalled, bytes and table writes alike
// input stall rises only while the output register is full and stalled
// index8 pixels read the table memory on the accepting edge, alongside the output register
// reset (synchronous, active low): rle off, bgr24, one pixel, parse cleared
// colour table contents are not cleared, unwritten entries read undefined
// ----------------------------------------------------------------------------
module tga_pixel_stream_decoder_top #(
    parameter int unsigned TABLE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,

    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [7:0]  i_data_byte,
    input  logic [7:0]  i_table_index,
    input  logic [23:0] i_table_value,

    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_red_or_gray,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    output logic [7:0]  o_repeat_count,
    output logic        o_last_pixel
);

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // configuration registers
    logic        r_rle_enable, n_rle_enable;
    logic [2:0]  r_pixel_kind, n_pixel_kind;
    logic [31:0] r_pixel_total, n_pixel_total;
    logic        w_cfg_wr;
    logic        w_restart;

    // output register
    logic        r_out_valid;
    logic        r_use_table;
    logic [7:0]  r_red;
    logic [7:0]  r_green;
    logic [7:0]  r_blue;
    logic [7:0]  r_alpha;
    logic [7:0]  r_count;
    logic        r_last;

    logic                 w_accept;
    logic                 w_advance;
    logic                 w_lookup_ok;
    logic                 w_wr_ok;
    logic [23:0]          w_rd_data;
    tgapsd_pkg::t_pix_res w_res;

    // ---------------- configuration ----------------
    // registers are always writable; writes must come only while the block is idle, which the block does not enforce
    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    always_comb begin
        n_rle_enable  = r_rle_enable;
        n_pixel_kind  = r_pixel_kind;
        n_pixel_total = r_pixel_total;
        w_restart     = 1'b0;
        if (w_cfg_wr) begin
            unique case (i_cfg_index)
                tgapsd_pkg::CFG_RLE_ENABLE: begin
                    n_rle_enable = i_cfg_data[0];
                    w_restart    = 1'b1;
                end
                tgapsd_pkg::CFG_PIXEL_KIND: begin
                    n_pixel_kind = i_cfg_data[2:0];
                    w_restart    = 1'b1;
                end
                tgapsd_pkg::CFG_PIXEL_TOTAL: begin
                    n_pixel_total = i_cfg_data;
                    w_restart     = 1'b1;
                end
                default: begin
                    // index beyond the register list: no effect
                    w_restart = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rle_enable  <= 1'b0;
            r_pixel_kind  <= tgapsd_pkg::KIND_BGR24;
            r_pixel_total <= 32'd1;
        end else begin
            r_rle_enable  <= n_rle_enable;
            r_pixel_kind  <= n_pixel_kind;
            r_pixel_total <= n_pixel_total;
        end
    end

    // ---------------- handshake ----------------
    // the output register frees up on the same edge it is taken
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_advance  = !o_in_stall;
    assign w_accept   = i_in_valid && w_advance;

    // ---------------- parser ----------------
    tgapsd_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_restart       (w_restart),
        .i_restart_total (n_pixel_total),
        .i_rle_enable    (r_rle_enable),
        .i_pixel_kind    (r_pixel_kind),
        .i_step          (w_accept && (i_cmd == tgapsd_pkg::CMD_DATA)),
        .i_byte          (i_data_byte),
        .o_res           (w_res)
    );

    // ---------------- colour table ----------------
    // out-of-range writes are dropped, out-of-range lookups give black
    assign w_wr_ok     = ({1'b0, i_table_index} < 9'(TABLE_DEPTH));
    assign w_lookup_ok = ({1'b0, w_res.idx} < 9'(TABLE_DEPTH));

    tgapsd_ctable #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ctable (
        .i_clk     (i_clk),
        .i_wr_en   (w_accept && (i_cmd == tgapsd_pkg::CMD_TABLE) && w_wr_ok),
        .i_wr_addr (i_table_index[AW-1:0]),
        .i_wr_data (i_table_value),
        // read only on advance so the data holds while the result waits
        .i_rd_en   (w_advance && w_res.valid && w_res.use_table && w_lookup_ok),
        .i_rd_addr (w_res.idx[AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_use_table <= w_res.use_table && w_lookup_ok;
            r_red       <= w_res.red;
            r_green     <= w_res.green;
            r_blue      <= w_res.blue;
            r_alpha     <= w_res.alpha;
            r_count     <= w_res.count;
            r_last      <= w_res.last;
        end
    end

    // table entries are stored blue low, green middle, red high
    assign o_out_valid    = r_out_valid;
    assign o_red_or_gray  = r_use_table ? w_rd_data[23:16] : r_red;
    assign o_green        = r_use_table ? w_rd_data[15:8]  : r_green;
    assign o_blue         = r_use_table ? w_rd_data[7:0]   : r_blue;
    assign o_alpha        = r_alpha;
    assign o_repeat_count = r_count;
    assign o_last_pixel   = r_last;

    // every result carries at least one pixel
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_count != 8'd0))
        else $error("result with zero repeat count");

endmodule

@@ tb/tgapsd_pixel_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tgapsd_pixel_checker
// watches the config, byte and pixel channels of the tga pixel stream decoder,
// decodes the accepted byte stream on its own and compares every pixel
// ----------------------------------------------------------------------------
module tgapsd_pixel_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,

    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_cmd,
    input  logic [7:0]  i_data_byte,
    input  logic [7:0]  i_table_index,
    input  logic [23:0] i_table_value,

    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_red_or_gray,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [7:0]  i_alpha,
    input  logic [7:0]  i_repeat_count,
    input  logic        i_last_pixel,

    output int          o_mismatches,
    output int          o_pixels_pending
);

    localparam int unsigned PRINT_LIMIT = 60;

    typedef enum logic {
        PH_HEADER,
        PH_PIXEL
    } t_parse_phase;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] count;
        logic       last;
    } t_pixel;

    // register copy
    logic        cfg_rle;
    logic [2:0]  cfg_kind;
    logic [31:0] cfg_total;

    // parse state
    t_parse_phase parse_phase;
    logic         run_packet;
    logic [7:0]   packet_left;
    int unsigned  byte_pos;
    logic [31:0]  pixel_word;
    logic [31:0]  pixels_left;
    logic         image_done;
    logic [23:0]  color_table [256];

    t_pixel expected_pixels [$];
    int     mismatches = 0;

    assign o_mismatches = mismatches;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("%0t ns: pixel mismatch on %s: got %0h, expected %0h",
                     $time, what, got, want);
    endtask

    function automatic void restart_image();
        parse_phase = PH_HEADER;
        run_packet  = 1'b0;
        packet_left = '0;
        byte_pos    = 0;
        pixel_word  = '0;
        pixels_left = cfg_total;
        image_done  = (cfg_total == 0);
    endfunction

    function automatic t_pixel decode_pixel(input logic [31:0] word);
        t_pixel p;
        p = '0;
        p.alpha = tgapsd_pkg::ALPHA_OPAQUE;
        case (cfg_kind)
            tgapsd_pkg::KIND_GRAY8: begin
                p.red = word[7:0];
            end
            tgapsd_pkg::KIND_INDEX8: begin
                {p.red, p.green, p.blue} = color_table[word[7:0]];
            end
            tgapsd_pkg::KIND_RGB555: begin
                // top bit of the word carries nothing
                p.red   = {word[14:10], 3'b000};
                p.green = {word[9:5], 3'b000};
                p.blue  = {word[4:0], 3'b000};
            end
            tgapsd_pkg::KIND_BGRA32: begin
                {p.alpha, p.red, p.green, p.blue} = word;
            end
            default: begin
                {p.red, p.green, p.blue} = word[23:0];
            end
        endcase
        return p;
    endfunction

    // one accepted transaction on the byte channel
    function automatic void decode_stream_byte(input logic cmd, input logic [7:0] data,
                                               input logic [7:0] idx,
                                               input logic [23:0] value);
        t_pixel      p;
        int unsigned width;
        logic [31:0] count;
        if (cmd == tgapsd_pkg::CMD_TABLE) begin
            color_table[idx] = value;
            return;
        end
        if (image_done)
            return;
        if (cfg_rle && parse_phase == PH_HEADER) begin
            run_packet  = data[7];
            packet_left = {1'b0, data[6:0]} + 8'd1;
            parse_phase = PH_PIXEL;
            byte_pos    = 0;
            pixel_word  = '0;
            return;
        end
        case (cfg_kind)
            tgapsd_pkg::KIND_GRAY8, tgapsd_pkg::KIND_INDEX8: width = 1;
            tgapsd_pkg::KIND_RGB555:                         width = 2;
            tgapsd_pkg::KIND_BGRA32:                         width = 4;
            default:                                         width = 3;
        endcase
        pixel_word = pixel_word | (32'(data) << (8 * byte_pos));
        if (byte_pos + 1 < width) begin
            byte_pos++;
            return;
        end
        p = decode_pixel(pixel_word);
        byte_pos   = 0;
        pixel_word = '0;
        if (cfg_rle && run_packet) begin
            count       = 32'(packet_left);
            packet_left = '0;
        end else begin
            count = 1;
            if (cfg_rle && packet_left > 0)
                packet_left--;
        end
        if (count > pixels_left)
            count = pixels_left;
        if (cfg_rle && packet_left == 0)
            parse_phase = PH_HEADER;
        pixels_left = pixels_left - count;
        if (pixels_left == 0)
            image_done = 1'b1;
        p.count = count[7:0];
        p.last  = image_done;
        expected_pixels.push_back(p);
    endfunction

    function automatic void write_register(input logic [1:0] index, input logic [31:0] data);
        case (index)
            tgapsd_pkg::CFG_RLE_ENABLE:  cfg_rle   = data[0];
            tgapsd_pkg::CFG_PIXEL_KIND:  cfg_kind  = data[2:0];
            tgapsd_pkg::CFG_PIXEL_TOTAL: cfg_total = data;
            default:                     return;
        endcase
        restart_image();
    endfunction

    task automatic check_pixel();
        t_pixel want;
        if (expected_pixels.size() == 0) begin
            report_mismatch("unexpected pixel, repeat_count", 32'(i_repeat_count), '0);
            return;
        end
        want = expected_pixels.pop_front();
        if (i_red_or_gray !== want.red)
            report_mismatch("red_or_gray", 32'(i_red_or_gray), 32'(want.red));
        if (i_green !== want.green)
            report_mismatch("green", 32'(i_green), 32'(want.green));
        if (i_blue !== want.blue)
            report_mismatch("blue", 32'(i_blue), 32'(want.blue));
        if (i_alpha !== want.alpha)
            report_mismatch("alpha", 32'(i_alpha), 32'(want.alpha));
        if (i_repeat_count !== want.count)
            report_mismatch("repeat_count", 32'(i_repeat_count), 32'(want.count));
        if (i_last_pixel !== want.last)
            report_mismatch("last_pixel", 32'(i_last_pixel), 32'(want.last));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_rle   = 1'b0;
            cfg_kind  = tgapsd_pkg::KIND_BGR24;
            cfg_total = 32'd1;
            restart_image();
            expected_pixels.delete();
        end else begin
            if (i_out_valid && !i_out_stall)
                check_pixel();
            if (i_cfg_valid && i_cfg_ready)
                write_register(i_cfg_index, i_cfg_data);
            if (i_in_valid && !i_in_stall)
                decode_stream_byte(i_cmd, i_data_byte, i_table_index, i_table_value);
        end
        o_pixels_pending <= expected_pixels.size();
    end

endmodule

@@ tb/tga_pixel_stream_decoder_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tga_pixel_stream_decoder_top_test
// drives byte streams, colour table writes and mode changes into the decoder
// under random idling and back pressure; the checker judges every pixel
// ----------------------------------------------------------------------------
module tga_pixel_stream_decoder_top_test;

    localparam int unsigned RANDOM_ITEMS   = 1100;
    localparam int unsigned IDLE_PERCENT   = 27;
    localparam int unsigned HOLD_CYCLES    = 150;
    localparam int unsigned HOLD_PIXELS    = 16;
    localparam int unsigned SETTLE_CYCLES  = 3;    // result is registered on the edge that accepts its byte
    localparam int unsigned DRAIN_CYCLES   = 10;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam logic [31:0] PIXEL_TOTAL_MAX = 32'd4294836225;
    localparam logic [2:0]  KIND_SPARE_LAST = 3'd7;  // unused kind, behaves as bgr24

    logic        clk;
    logic        rst_n;

    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    logic        in_valid;
    logic        in_stall;
    logic        cmd;
    logic [7:0]  data_byte;
    logic [7:0]  table_index;
    logic [23:0] table_value;

    logic        out_valid;
    logic        out_stall;
    logic [7:0]  red_or_gray;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  repeat_count;
    logic        last_pixel;

    int          mismatches;
    int          pixels_pending;

    // calm: neither side idles; hold_req: receiver holds off for a long stretch
    bit          calm     = 1'b0;
    bit          hold_req = 1'b0;
    int unsigned items_sent = 0;

    tga_pixel_stream_decoder_top u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_cmd          (cmd),
        .i_data_byte    (data_byte),
        .i_table_index  (table_index),
        .i_table_value  (table_value),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_red_or_gray  (red_or_gray),
        .o_green        (green),
        .o_blue         (blue),
        .o_alpha        (alpha),
        .o_repeat_count (repeat_count),
        .o_last_pixel   (last_pixel)
    );

    tgapsd_pixel_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_cmd            (cmd),
        .i_data_byte      (data_byte),
        .i_table_index    (table_index),
        .i_table_value    (table_value),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_red_or_gray    (red_or_gray),
        .i_green          (green),
        .i_blue           (blue),
        .i_alpha          (alpha),
        .i_repeat_count   (repeat_count),
        .i_last_pixel     (last_pixel),
        .o_mismatches     (mismatches),
        .o_pixels_pending (pixels_pending)
    );

    // 8 ns clock
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // pixel receiver: random stall, none while calm, one long hold-off on request
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                // block fills its output register and then stalls the byte side
                out_stall = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end else begin
                out_stall = !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
            end
        end
    end

    // watchdog: cycles in a row with no transaction on any channel
    initial begin
        int unsigned quiet;
        quiet = 0;
        forever begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // one transaction on the byte channel; entered and left at a falling edge,
    // valid stays high on return so a back-to-back transaction needs no gap
    task automatic send_item(input logic c, input logic [7:0] b, input logic [7:0] ti,
                             input logic [23:0] tv);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid    = 1'b1;
        cmd         = c;
        data_byte   = b;
        table_index = ti;
        table_value = tv;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        items_sent++;
    endtask

    // stream byte, now and then preceded by a colour table write
    task automatic send_data(input logic [7:0] b);
        if ($urandom_range(0, 99) < 6)
            send_item(tgapsd_pkg::CMD_TABLE, 8'($urandom), 8'($urandom), 24'($urandom));
        send_item(tgapsd_pkg::CMD_DATA, b, 8'($urandom), 24'($urandom));
    endtask

    // register writes only once every pending pixel is out and the pipe is quiet
    task automatic write_reg(input logic [1:0] r, input logic [31:0] v);
        in_valid = 1'b0;
        while (pixels_pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = r;
        cfg_data  = v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_mode(input logic rle, input logic [2:0] kind, input logic [31:0] total);
        write_reg(tgapsd_pkg::CFG_RLE_ENABLE, 32'(rle));
        write_reg(tgapsd_pkg::CFG_PIXEL_KIND, 32'(kind));
        write_reg(tgapsd_pkg::CFG_PIXEL_TOTAL, total);
    endtask

    // one random image: mostly well-formed packets with random content,
    // sometimes a broken burst of raw noise
    task automatic play_image();
        logic        rle;
        logic        run;
        logic [2:0]  kind;
        logic [31:0] total;
        longint      owed;
        int unsigned pick;
        int unsigned width;
        int unsigned budget;
        int unsigned bytes;
        int unsigned len;
        int unsigned npix;
        pick  = $urandom_range(0, 99);
        rle   = 1'($urandom_range(0, 1));
        kind  = ($urandom_range(0, 99) < 12) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
        if (pick < 8)
            total = 32'd0;
        else if (pick < 18)
            total = 32'd1;
        else if (pick < 23)
            total = PIXEL_TOTAL_MAX;
        else
            total = 32'($urandom_range(2, 40));

        // occasionally change only one register, restarting the image in place
        if ($urandom_range(0, 99) < 15)
            write_reg(tgapsd_pkg::CFG_RLE_ENABLE, 32'(rle));
        else
            set_mode(rle, kind, total);

        if ($urandom_range(0, 99) < 12) begin
            // noise: may stop mid pixel or mid packet, next mode write restarts
            repeat ($urandom_range(1, 24))
                send_item(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom),
                          24'($urandom));
            return;
        end

        width  = tgapsd_pkg::bytes_per_pixel(kind);
        owed   = longint'(total);
        budget = $urandom_range(20, 120);
        bytes  = 0;
        while (owed > 0 && bytes < budget) begin
            if (rle) begin
                run = 1'($urandom_range(0, 1));
                len = ($urandom_range(0, 99) < 75) ? $urandom_range(1, 8)
                                                   : $urandom_range(1, tgapsd_pkg::MAX_PACKET);
                send_data({run, 7'(len - 1)});
                bytes++;
                npix = run ? 1 : len;
                for (int p = 0; p < npix && bytes < budget; p++) begin
                    repeat (width) send_data(8'($urandom));
                    bytes += width;
                end
                owed -= run ? len : npix;
            end else begin
                repeat (width) send_data(8'($urandom));
                bytes += width;
                owed--;
            end
        end
        // trailing bytes are dropped by the block if the image end was reached
        if (owed <= 0 && $urandom_range(0, 99) < 30)
            repeat ($urandom_range(1, 4)) send_data(8'($urandom));
    endtask

    initial begin
        int unsigned random_start;
        int unsigned image_no;

        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = tgapsd_pkg::CFG_RLE_ENABLE;
        cfg_data    = '0;
        in_valid    = 1'b0;
        cmd         = tgapsd_pkg::CMD_DATA;
        data_byte   = '0;
        table_index = '0;
        table_value = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ---- directed part ----
        // reset mode: raw bgr24, one pixel; then a byte after the image end
        send_item(tgapsd_pkg::CMD_DATA, 8'h00, 8'h00, 24'h000000);
        send_item(tgapsd_pkg::CMD_DATA, 8'h80, 8'hFF, 24'hFFFFFF);
        send_item(tgapsd_pkg::CMD_DATA, 8'hFF, 8'h00, 24'h000000);
        send_item(tgapsd_pkg::CMD_DATA, 8'h5A, 8'h00, 24'h000000);

        // table writes at both ends of the index range, no result
        send_item(tgapsd_pkg::CMD_TABLE, 8'h00, 8'hFF, 24'hFFFFFF);
        send_item(tgapsd_pkg::CMD_TABLE, 8'hFF, 8'h00, 24'h5AA50F);

        // index8 with rle: full-length run, single raw pixel, short run
        set_mode(1'b1, tgapsd_pkg::KIND_INDEX8, 32'd200);
        send_item(tgapsd_pkg::CMD_DATA, 8'hFF, 8'h00, 24'h000000);
        send_item(tgapsd_pkg::CMD_DATA, 8'hFF, 8'h00, 24'h000000);
        send_item(tgapsd_pkg::CMD_DATA, 8'h00, 8'h00, 24'h000000);
        send_item(tgapsd_pkg::CMD_DATA, 8'h00, 8'h00, 24'h000000);
        send_item(tgapsd_pkg::CMD_DATA, 8'h81, 8'h00, 24'h000000);
        send_item(tgapsd_pkg::CMD_DATA, 8'h00, 8'h00, 24'h000000);

        // raw gray8, two pixels, both byte extremes
        set_mode(1'b0, tgapsd_pkg::KIND_GRAY8, 32'd2);
        send_item(tgapsd_pkg::CMD_DATA, 8'h00, 8'h00, 24'h000000);
        send_item(tgapsd_pkg::CMD_DATA, 8'hFF, 8'h00, 24'h000000);

        // rgb555 run longer than the image, count gets clamped
        set_mode(1'b1, tgapsd_pkg::KIND_RGB555, 32'd5);
        send_item(tgapsd_pkg::CMD_DATA, 8'h85, 8'h00, 24'h000000);
        send_item(tgapsd_pkg::CMD_DATA, 8'hFF, 8'h00, 24'h000000);
        send_item(tgapsd_pkg::CMD_DATA, 8'hFF, 8'h00, 24'h000000);

        // raw packet running past the image end
        set_mode(1'b1, tgapsd_pkg::KIND_GRAY8, 32'd2);
        send_item(tgapsd_pkg::CMD_DATA, 8'h03, 8'h00, 24'h000000);
        send_item(tgapsd_pkg::CMD_DATA, 8'h01, 8'h00, 24'h000000);
        send_item(tgapsd_pkg::CMD_DATA, 8'h02, 8'h00, 24'h000000);
        send_item(tgapsd_pkg::CMD_DATA, 8'h03, 8'h00, 24'h000000);

        // bgra32 with its own alpha
        set_mode(1'b0, tgapsd_pkg::KIND_BGRA32, 32'd1);
        send_item(tgapsd_pkg::CMD_DATA, 8'h00, 8'h00, 24'h000000);
        send_item(tgapsd_pkg::CMD_DATA, 8'hFF, 8'h00, 24'h000000);
        send_item(tgapsd_pkg::CMD_DATA, 8'h7F, 8'h00, 24'h000000);
        send_item(tgapsd_pkg::CMD_DATA, 8'h80, 8'h00, 24'h000000);

        // unused kind decodes as bgr24
        set_mode(1'b0, KIND_SPARE_LAST, 32'd1);
        send_item(tgapsd_pkg::CMD_DATA, 8'h12, 8'h00, 24'h000000);
        send_item(tgapsd_pkg::CMD_DATA, 8'h34, 8'h00, 24'h000000);
        send_item(tgapsd_pkg::CMD_DATA, 8'h56, 8'h00, 24'h000000);

        // zero-pixel image drops everything
        write_reg(tgapsd_pkg::CFG_PIXEL_TOTAL, 32'd0);
        send_item(tgapsd_pkg::CMD_DATA, 8'hAA, 8'h00, 24'h000000);
        send_item(tgapsd_pkg::CMD_DATA, 8'h55, 8'h00, 24'h000000);

        // receiver holds off while gray8 bytes keep coming: output fills, input stalls
        set_mode(1'b0, tgapsd_pkg::KIND_GRAY8, 32'(HOLD_PIXELS));
        hold_req = 1'b1;
        repeat (HOLD_PIXELS)
            send_item(tgapsd_pkg::CMD_DATA, 8'($urandom), 8'h00, 24'h000000);

        // ---- random part ----
        // fill the whole colour table first so any index byte reads a written entry
        for (int i = 0; i < 256; i++)
            send_item(tgapsd_pkg::CMD_TABLE, 8'($urandom), 8'(i), 24'($urandom));

        random_start = items_sent;
        image_no     = 0;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            if (image_no == 5)
                hold_req = 1'b1;
            calm = (image_no >= 15 && image_no < 23);
            play_image();
            image_no++;
        end
        calm = 1'b0;

        // drain, then give the pipe a little time to show any stray pixel
        in_valid = 1'b0;
        while (pixels_pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/tgapsd_pkg.sv
rtl/core/tgapsd_ctable.sv
rtl/core/tgapsd_parser.sv
rtl/core/tga_pixel_stream_decoder_top.sv
tb/tgapsd_pixel_checker.sv
tb/tga_pixel_stream_decoder_top_test.sv
